[design/fcsc_pkg.sv]
// Types, constants and helpers shared by the fan curve speed controller.
// No dependencies; imported by every module of the block.
package fcsc_pkg;

  localparam int unsigned MaxPoints    = 8;
  localparam int unsigned NumWords     = 4;
  localparam int unsigned PointIdxW    = 3;
  localparam int unsigned TempW        = 8;
  localparam int unsigned PctW         = 7;
  localparam int unsigned DutyW        = 8;
  localparam int unsigned CntW         = 4;
  localparam int unsigned ProdW        = 15;
  localparam int unsigned DivCntW      = 4;
  localparam int unsigned DataW        = 32;
  localparam int unsigned CfgAddrW     = 5;
  localparam int unsigned RecipW       = 18;
  localparam int unsigned DutyProdW    = PctW + RecipW;

  localparam logic [PctW-1:0]   PctMax     = 7'd100;
  localparam logic [CntW-1:0]   CntMax     = 4'd15;
  // 2.55 in 16-bit fraction, rounded up: floor(p*255/100) for p up to 100
  localparam logic [RecipW-1:0] DutyRecip  = 18'd167117;
  localparam logic [DataW-1:0]  CurveAInit = 32'h6450_1428;

  typedef enum logic [2:0] {
    RegCurveA     = 3'd0,
    RegCurveB     = 3'd1,
    RegCurveC     = 3'd2,
    RegCurveD     = 3'd3,
    RegPointCount = 3'd4,
    RegIgnoreMem  = 3'd5,
    RegHoldTicks  = 3'd6,
    RegMaxStep    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [TempW-1:0] edge_temp;
    logic [TempW-1:0] hotspot_temp;
    logic [TempW-1:0] memory_temp;
  } in_item_t;

  typedef struct packed {
    logic [PctW-1:0]  fan_percent;
    logic [DutyW-1:0] duty_code;
    logic             write_duty;
    logic             fault;
  } out_item_t;

  typedef logic [NumWords-1:0][DataW-1:0] curve_t;

  typedef struct packed {
    curve_t          curve;
    logic [CntW-1:0] point_count;
    logic            ignore_memory_temp;
    logic [CntW-1:0] hold_ticks;
    logic [PctW-1:0] max_step_down;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic clamp_first;
    logic clamp_last;
    logic idx_init;
    logic idx_next;
    logic div_start;
    logic div_step;
    logic div_finish;
    logic decide;
    logic set_fault;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic t_zero;
    logic t_le_first;
    logic t_ge_last;
    logic t_le_idx;
    logic div_last;
  } sts_t;

  function automatic logic [TempW-1:0] pt_temp(curve_t c, logic [PointIdxW-1:0] i);
    logic [DataW-1:0] w;
    w = c[i[PointIdxW-1:1]];
    return i[0] ? w[23:16] : w[7:0];
  endfunction

  function automatic logic [PctW-1:0] pt_pct(curve_t c, logic [PointIdxW-1:0] i);
    logic [DataW-1:0] w;
    logic [7:0]       raw;
    w   = c[i[PointIdxW-1:1]];
    raw = i[0] ? w[31:24] : w[15:8];
    return (raw > {1'b0, PctMax}) ? PctMax : raw[PctW-1:0];
  endfunction

  function automatic logic [DutyW-1:0] duty_of(logic [PctW-1:0] p);
    logic [DutyProdW-1:0] prod;
    prod = DutyProdW'(p) * DutyProdW'(DutyRecip);
    return prod[23:16];
  endfunction

endpackage

[design/fcsc_regs.sv]
// APB-style configuration register file of the fan curve speed controller.
// Depends on fcsc_pkg.
module fcsc_regs
  import fcsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.curve              <= curve_t'({32'd0, 32'd0, 32'd0, CurveAInit});
      cfg_q.point_count        <= CntW'(2);
      cfg_q.ignore_memory_temp <= 1'b0;
      cfg_q.hold_ticks         <= CntW'(8);
      cfg_q.max_step_down      <= PctW'(5);
    end else if (wr_en) begin
      case (idx)
        RegCurveA:     cfg_q.curve[0]           <= pwdata;
        RegCurveB:     cfg_q.curve[1]           <= pwdata;
        RegCurveC:     cfg_q.curve[2]           <= pwdata;
        RegCurveD:     cfg_q.curve[3]           <= pwdata;
        RegPointCount: cfg_q.point_count        <= pwdata[CntW-1:0];
        RegIgnoreMem:  cfg_q.ignore_memory_temp <= pwdata[0];
        RegHoldTicks:  cfg_q.hold_ticks         <= pwdata[CntW-1:0];
        RegMaxStep:    cfg_q.max_step_down      <= pwdata[PctW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegCurveA:     prdata = cfg_q.curve[0];
      RegCurveB:     prdata = cfg_q.curve[1];
      RegCurveC:     prdata = cfg_q.curve[2];
      RegCurveD:     prdata = cfg_q.curve[3];
      RegPointCount: prdata = DataW'(cfg_q.point_count);
      RegIgnoreMem:  prdata = DataW'(cfg_q.ignore_memory_temp);
      RegHoldTicks:  prdata = DataW'(cfg_q.hold_ticks);
      RegMaxStep:    prdata = DataW'(cfg_q.max_step_down);
      default:       prdata = '0;
    endcase
  end

endmodule

[design/fcsc_ctrl.sv]
// Sequencer of the fan curve speed controller: handshakes and datapath commands.
// Depends on fcsc_pkg.
module fcsc_ctrl
  import fcsc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StScan,
    StDiv,
    StQuot,
    StDecide,
    StEmit
  } state_e;

  state_e state_q;
  logic   in_stall_q;
  logic   out_valid_q;
  logic   can_emit;

  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;
  assign can_emit    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle:  cmd_o.capture = in_valid_i;
      StCheck: begin
        if (sts_i.t_zero) begin
          cmd_o.set_fault = 1'b1;
        end else if (sts_i.t_le_first) begin
          cmd_o.clamp_first = 1'b1;
        end else if (sts_i.t_ge_last) begin
          cmd_o.clamp_last = 1'b1;
        end else begin
          cmd_o.idx_init = 1'b1;
        end
      end
      StScan: begin
        if (sts_i.t_le_idx) begin
          cmd_o.div_start = 1'b1;
        end else begin
          cmd_o.idx_next = 1'b1;
        end
      end
      StDiv:    cmd_o.div_step   = 1'b1;
      StQuot:   cmd_o.div_finish = 1'b1;
      StDecide: cmd_o.decide     = 1'b1;
      StEmit:   cmd_o.emit       = can_emit;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      in_stall_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q    <= StCheck;
            in_stall_q <= 1'b1;
          end
        end
        StCheck: begin
          if (sts_i.t_zero) begin
            state_q <= StEmit;
          end else if (sts_i.t_le_first || sts_i.t_ge_last) begin
            state_q <= StDecide;
          end else begin
            state_q <= StScan;
          end
        end
        StScan: begin
          if (sts_i.t_le_idx) begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (sts_i.div_last) begin
            state_q <= StQuot;
          end
        end
        StQuot:   state_q <= StDecide;
        StDecide: state_q <= StEmit;
        StEmit: begin
          if (can_emit) begin
            state_q    <= StIdle;
            in_stall_q <= 1'b0;
          end
        end
        default: begin
          state_q    <= StIdle;
          in_stall_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

[design/fcsc_dp.sv]
// Datapath of the fan curve speed controller: hottest pick, segment scan,
// restoring divider, hold/step-down logic and result register. Depends on fcsc_pkg.
module fcsc_dp
  import fcsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  in_item_t  in_data_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output out_item_t out_data_o
);

  logic [TempW-1:0]     t_q;
  logic [PointIdxW-1:0] idx_q;
  logic [PctW-1:0]      target_q;
  logic [PctW-1:0]      lp_q;
  logic                 rising_q;
  logic [TempW-1:0]     span_q;
  logic [ProdW-1:0]     dq_q;
  logic [TempW-1:0]     rem_q;
  logic [DivCntW-1:0]   div_cnt_q;
  logic                 write_q;
  logic                 fault_q;
  out_item_t            out_q;

  logic [PctW-1:0]      applied_q;
  logic                 applied_valid_q;
  logic [CntW-1:0]      lower_cnt_q;

  // hottest temperature
  logic [TempW-1:0] eh_max;
  logic [TempW-1:0] hottest;
  assign eh_max  = (in_data_i.hotspot_temp > in_data_i.edge_temp) ?
                   in_data_i.hotspot_temp : in_data_i.edge_temp;
  assign hottest = (!cfg_i.ignore_memory_temp && (in_data_i.memory_temp > eh_max)) ?
                   in_data_i.memory_temp : eh_max;

  // last point in use
  logic [PointIdxW-1:0] last_idx;
  always_comb begin
    if (cfg_i.point_count < CntW'(2)) begin
      last_idx = PointIdxW'(1);
    end else if (cfg_i.point_count > CntW'(MaxPoints)) begin
      last_idx = PointIdxW'(MaxPoints - 1);
    end else begin
      last_idx = PointIdxW'(cfg_i.point_count - CntW'(1));
    end
  end

  assign sts_o.t_zero     = (t_q == '0);
  assign sts_o.t_le_first = (t_q <= pt_temp(cfg_i.curve, '0));
  assign sts_o.t_ge_last  = (t_q >= pt_temp(cfg_i.curve, last_idx));
  assign sts_o.t_le_idx   = (t_q <= pt_temp(cfg_i.curve, idx_q));
  assign sts_o.div_last   = (div_cnt_q == DivCntW'(ProdW - 1));

  // segment ending at idx_q; t_q lies strictly above its lower end
  logic [PointIdxW-1:0] lo_idx;
  logic [TempW-1:0]     seg_lt;
  logic [TempW-1:0]     seg_ht;
  logic [PctW-1:0]      seg_lp;
  logic [PctW-1:0]      seg_hp;
  logic                 seg_rising;
  logic [PctW-1:0]      seg_diff;
  logic [ProdW-1:0]     seg_prod;
  assign lo_idx     = idx_q - PointIdxW'(1);
  assign seg_lt     = pt_temp(cfg_i.curve, lo_idx);
  assign seg_ht     = pt_temp(cfg_i.curve, idx_q);
  assign seg_lp     = pt_pct(cfg_i.curve, lo_idx);
  assign seg_hp     = pt_pct(cfg_i.curve, idx_q);
  assign seg_rising = (seg_hp >= seg_lp);
  assign seg_diff   = seg_rising ? (seg_hp - seg_lp) : (seg_lp - seg_hp);
  assign seg_prod   = ProdW'(t_q - seg_lt) * ProdW'(seg_diff);

  // one restoring divide step
  logic [TempW:0]   div_shift;
  logic [TempW:0]   div_trial;
  logic             div_bit;
  logic [PctW-1:0]  quot;
  assign div_shift = {rem_q, dq_q[ProdW-1]};
  assign div_trial = div_shift - {1'b0, span_q};
  assign div_bit   = (div_shift >= {1'b0, span_q});
  assign quot      = dq_q[PctW-1:0];

  // hold and step-down decision
  logic [CntW-1:0] cnt_inc;
  logic [PctW-1:0] drop;
  logic            dec_wr;
  logic [PctW-1:0] dec_pct;
  logic [CntW-1:0] dec_cnt;
  assign cnt_inc = (lower_cnt_q == CntMax) ? CntMax : (lower_cnt_q + CntW'(1));
  assign drop    = applied_q - target_q;

  always_comb begin
    dec_wr  = 1'b0;
    dec_pct = target_q;
    dec_cnt = lower_cnt_q;
    if (!applied_valid_q || (target_q > applied_q)) begin
      dec_wr = 1'b1;
    end else if (target_q < applied_q) begin
      dec_cnt = cnt_inc;
      if (cnt_inc >= cfg_i.hold_ticks) begin
        dec_wr = 1'b1;
        if (drop > cfg_i.max_step_down) begin
          dec_pct = applied_q - cfg_i.max_step_down;
        end
      end
    end
    if (dec_wr) begin
      dec_cnt = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      applied_q       <= '0;
      applied_valid_q <= 1'b0;
      lower_cnt_q     <= '0;
    end else if (cmd_i.decide) begin
      lower_cnt_q <= dec_cnt;
      if (dec_wr) begin
        applied_q       <= dec_pct;
        applied_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      t_q <= hottest;
    end
    if (cmd_i.idx_init) begin
      idx_q <= PointIdxW'(1);
    end else if (cmd_i.idx_next) begin
      idx_q <= idx_q + PointIdxW'(1);
    end
    if (cmd_i.clamp_first) begin
      target_q <= pt_pct(cfg_i.curve, '0);
    end else if (cmd_i.clamp_last) begin
      target_q <= pt_pct(cfg_i.curve, last_idx);
    end else if (cmd_i.div_finish) begin
      target_q <= rising_q ? (lp_q + quot) : (lp_q - quot);
    end
    if (cmd_i.div_start) begin
      lp_q      <= seg_lp;
      rising_q  <= seg_rising;
      span_q    <= seg_ht - seg_lt;
      dq_q      <= seg_prod;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q      <= {dq_q[ProdW-2:0], div_bit};
      rem_q     <= div_bit ? div_trial[TempW-1:0] : div_shift[TempW-1:0];
      div_cnt_q <= div_cnt_q + DivCntW'(1);
    end
    if (cmd_i.set_fault) begin
      write_q <= 1'b0;
      fault_q <= 1'b1;
    end else if (cmd_i.decide) begin
      write_q <= dec_wr;
      fault_q <= 1'b0;
    end
    if (cmd_i.emit) begin
      out_q.fan_percent <= applied_q;
      out_q.duty_code   <= duty_of(applied_q);
      out_q.write_duty  <= write_q;
      out_q.fault       <= fault_q;
    end
  end

  assign out_data_o = out_q;

endmodule

[design/fan_curve_speed_controller.sv]
// Top level of the fan curve speed controller.
// Depends on fcsc_pkg, fcsc_regs, fcsc_ctrl and fcsc_dp.
//
// One transaction of three temperatures in gives one result transaction out. The hottest
// value (memory optional) is mapped through a piecewise-linear curve of up to eight points,
// rises are applied at once, falls only after hold_ticks lower ticks and by at most
// max_step_down; a zero hottest temperature flags fault and changes nothing. A fault goes
// straight from the check to the result register, a clamp passes the hold/step-down
// decision first, and an interpolation scans 1 to 7 segments and runs the 15-step restoring
// divider before it decides. Input is stalled while a transaction is in progress and taken
// again the cycle after its result is registered; a result may wait in the output register
// while the next transaction runs. Configuration registers sit at byte addresses 4*i;
// they must be written by the user only while idle, unenforced by the block.
module fan_curve_speed_controller
  import fcsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  fcsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fcsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fcsc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

[design/fcsc_checker.sv]
// Port-level checks of the fan curve speed controller, bound to its top level.
// Depends on fcsc_pkg and fan_curve_speed_controller.
module fcsc_checker
  import fcsc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled while transaction in progress");

  a_fault_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.fault && out_data_o.write_duty))
    else $error("duty written on fault");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.fan_percent <= PctMax))
    else $error("fan percent above 100");

  a_duty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.fan_percent == PctMax) == (out_data_o.duty_code == '1)))
    else $error("duty code inconsistent with full speed");

endmodule

bind fan_curve_speed_controller fcsc_checker u_fcsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[sim/tb.sv]
// Self-checking testbench for fan_curve_speed_controller: tick transactions in, duty results out.
// Depends on fcsc_pkg and the RTL only; predicts every result with its own fan curve model.
module tb;
  import fcsc_pkg::*;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAddrW-1:0] paddr       = '0;
  logic [DataW-1:0]    pwdata      = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;

  fan_curve_speed_controller dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i, .out_data_o
  );

  always #10 clk_i = ~clk_i;

  // shadow of the register file
  curve_t          cfg_curve   = {32'd0, 32'd0, 32'd0, CurveAInit};
  logic [CntW-1:0] cfg_points  = 4'd2;
  logic            cfg_ign_mem = 1'b0;
  logic [CntW-1:0] cfg_hold    = 4'd8;
  logic [PctW-1:0] cfg_step    = 7'd5;

  // controller state
  int unsigned cur_pct   = 0;
  logic        pct_live  = 1'b0;
  int unsigned low_ticks = 0;

  in_item_t    tick_q [$];
  out_item_t   fan_due [$];
  logic        idle_on      = 1'b1;
  logic        long_hold_go = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned send_gap     = 0;
  int unsigned rcv_gap      = 0;
  int          walk_t       = 60;
  int          n_ticks      = 0;
  int          n_results    = 0;
  int          n_writes     = 0;
  int          n_faults     = 0;
  int          err_cnt      = 0;

  function automatic logic [TempW-1:0] knot_temp(int unsigned k);
    logic [DataW-1:0] w;
    w = cfg_curve[k >> 1];
    return k[0] ? w[23:16] : w[7:0];
  endfunction

  function automatic int unsigned knot_pct(int unsigned k);
    logic [DataW-1:0] w;
    int unsigned      raw;
    w   = cfg_curve[k >> 1];
    raw = k[0] ? w[31:24] : w[15:8];
    return (raw > 100) ? 100 : raw;
  endfunction

  function automatic int unsigned curve_pct(int unsigned t);
    int unsigned n, lo_t, hi_t, lo_p, hi_p;
    n = cfg_points;
    if (n < 2) n = 2;
    if (n > MaxPoints) n = MaxPoints;
    if (t <= knot_temp(0)) return knot_pct(0);
    if (t >= knot_temp(n - 1)) return knot_pct(n - 1);
    for (int unsigned k = 1; k < n; k++) begin
      if (t <= knot_temp(k)) begin
        lo_t = knot_temp(k - 1);
        hi_t = knot_temp(k);
        lo_p = knot_pct(k - 1);
        hi_p = knot_pct(k);
        if (hi_t == lo_t) return lo_p;
        if (hi_p >= lo_p) return lo_p + (t - lo_t) * (hi_p - lo_p) / (hi_t - lo_t);
        return lo_p - (t - lo_t) * (lo_p - hi_p) / (hi_t - lo_t);
      end
    end
    return knot_pct(n - 1);
  endfunction

  // one tick of the controller: updates state, returns the result it emits
  function automatic out_item_t fan_step(in_item_t it);
    int unsigned hottest, target;
    logic        wr, flt;
    out_item_t   r;
    hottest = it.edge_temp;
    if (it.hotspot_temp > hottest) hottest = it.hotspot_temp;
    if (!cfg_ign_mem && it.memory_temp > hottest) hottest = it.memory_temp;
    wr  = 1'b0;
    flt = (hottest == 0);
    if (!flt) begin
      target = curve_pct(hottest);
      if (!pct_live || target > cur_pct) begin
        wr = 1'b1;
      end else if (target < cur_pct) begin
        if (low_ticks < 15) low_ticks++;
        if (low_ticks >= cfg_hold) begin
          if (cur_pct - target > cfg_step) target = cur_pct - cfg_step;
          wr = 1'b1;
        end
      end
      if (wr) begin
        cur_pct   = target;
        pct_live  = 1'b1;
        low_ticks = 0;
      end
    end
    r.fan_percent = PctW'(cur_pct);
    r.duty_code   = DutyW'(cur_pct * 255 / 100);
    r.write_duty  = wr;
    r.fault       = flt;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly a drifting temperature with random content, some noise and zero readings
  function automatic in_item_t next_tick();
    in_item_t    it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return {16'd0, 8'($urandom_range(0, 255))};
    if (r < 14) return in_item_t'(24'($urandom));
    if (r < 19) walk_t = $urandom_range(1, 255);
    else walk_t = walk_t + int'($urandom_range(0, 12)) - 6;
    if (walk_t < 1) walk_t = 1;
    if (walk_t > 255) walk_t = 255;
    it.hotspot_temp = 8'(walk_t);
    it.edge_temp    = (walk_t > 8) ? 8'(walk_t - int'($urandom_range(0, 8))) : 8'(walk_t);
    it.memory_temp  = (r < 60) ? 8'($urandom_range(0, 255)) : it.edge_temp;
    return it;
  endfunction

  function automatic curve_t make_curve();
    curve_t      c;
    int unsigned t, p;
    t = $urandom_range(0, 60);
    p = $urandom_range(0, 40);
    for (int k = 0; k < MaxPoints; k++) begin
      c[k >> 1][(k % 2) * 16 +: 8]     = 8'(t);
      c[k >> 1][(k % 2) * 16 + 8 +: 8] = 8'(p);
      t = t + $urandom_range(0, 35);
      if (t > 255) t = 255;
      if ($urandom_range(0, 4) == 0) p = $urandom_range(0, 255);
      else p = p + $urandom_range(0, 25);
      if (p > 255) p = 255;
    end
    return c;
  endfunction

  task automatic cfg_write(reg_idx_e idx, logic [DataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegCurveA:     cfg_curve[0] = val;
      RegCurveB:     cfg_curve[1] = val;
      RegCurveC:     cfg_curve[2] = val;
      RegCurveD:     cfg_curve[3] = val;
      RegPointCount: cfg_points   = val[CntW-1:0];
      RegIgnoreMem:  cfg_ign_mem  = val[0];
      RegHoldTicks:  cfg_hold     = val[CntW-1:0];
      RegMaxStep:    cfg_step     = val[PctW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(curve_t c, int unsigned pc, int unsigned ig, int unsigned hd,
                           int unsigned st);
    cfg_write(RegCurveA, c[0]);
    cfg_write(RegCurveB, c[1]);
    cfg_write(RegCurveC, c[2]);
    cfg_write(RegCurveD, c[3]);
    cfg_write(RegPointCount, DataW'(pc));
    cfg_write(RegIgnoreMem, DataW'(ig));
    cfg_write(RegHoldTicks, DataW'(hd));
    cfg_write(RegMaxStep, DataW'(st));
  endtask

  // sender idle until every expected result is in, then the pipeline tail
  task automatic drain();
    do @(negedge clk_i); while (tick_q.size() != 0 || in_valid_i || fan_due.size() != 0);
    repeat (40) @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : feed
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        fan_due.push_back(fan_step(in_data_i));
        n_ticks++;
      end
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (tick_q.size() != 0) begin
        in_data_i  <= tick_q.pop_front();
        in_valid_i <= 1'b1;
        send_gap = idle_on ? pick_gap() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : hold_off
    if (long_hold_go) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rcv_gap = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (out_data_o.write_duty === 1'b1) n_writes++;
        if (out_data_o.fault === 1'b1) n_faults++;
        if (fan_due.size() == 0) begin
          if (err_cnt < 10) $display("unexpected result transaction %p", out_data_o);
          err_cnt++;
        end else begin
          want = fan_due.pop_front();
          if (out_data_o.fan_percent !== want.fan_percent ||
              out_data_o.duty_code !== want.duty_code ||
              out_data_o.write_duty !== want.write_duty ||
              out_data_o.fault !== want.fault) begin
            if (err_cnt < 10)
              $display("mismatch at result %0d: pct %0d/%0d duty %0d/%0d wr %b/%b fault %b/%b",
                       n_results, want.fan_percent, out_data_o.fan_percent, want.duty_code,
                       out_data_o.duty_code, want.write_duty, out_data_o.write_duty,
                       want.fault, out_data_o.fault);
            err_cnt++;
          end
        end
      end
      if (rcv_gap != 0) rcv_gap--;
      else if (idle_on) rcv_gap = pick_gap();
      out_stall_i <= (hold_left != 0) || (rcv_gap != 0);
    end
  end

  initial begin : stimulus
    curve_t      cw;
    int unsigned pc, ig, hd, st;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset curve: fault before first write, clamps, rise, equal, held fall
    tick_q.push_back({8'd0, 8'd0, 8'd0});
    tick_q.push_back({8'd30, 8'd10, 8'd5});
    tick_q.push_back({8'd60, 8'd0, 8'd0});
    tick_q.push_back({8'd0, 8'd0, 8'd255});
    tick_q.push_back({8'd255, 8'd255, 8'd255});
    repeat (9) tick_q.push_back({8'd50, 8'd50, 8'd50});
    drain();

    // eight points with a repeated temperature, a percent over 100 and a falling segment
    apply_cfg({32'h64FA_50C8, 32'h3C78_285A, 32'hC83C_321E, 32'h1E1E_050A}, 8, 1, 0, 0);
    tick_q.push_back({8'd0, 8'd0, 8'd200});
    tick_q.push_back({8'd75, 8'd0, 8'd0});
    tick_q.push_back({8'd5, 8'd5, 8'd5});
    tick_q.push_back({8'd255, 8'd1, 8'd1});
    tick_q.push_back({8'd30, 8'd0, 8'd0});
    tick_q.push_back({8'd45, 8'd30, 8'd0});
    tick_q.push_back({8'd0, 8'd95, 8'd90});
    tick_q.push_back({8'd130, 8'd0, 8'd0});
    tick_q.push_back({8'd201, 8'd0, 8'd0});
    tick_q.push_back({8'd25, 8'd0, 8'd0});
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      cw = make_curve();
      pc = $urandom_range(2, 8);
      ig = (ph < 2) ? ph : $urandom_range(0, 1);
      hd = $urandom_range(0, 15);
      st = ($urandom_range(0, 3) == 0) ? $urandom_range(101, 127) : $urandom_range(1, 100);
      case (ph)
        0: begin pc = 2; hd = 1; st = 1; end
        1: begin pc = 8; hd = 15; st = 100; end
        2: pc = $urandom_range(9, 15);
        3: begin pc = $urandom_range(0, 1); hd = 0; st = 0; end
        4: cw = '1;
        5: cw = '0;
        default: ;
      endcase
      apply_cfg(cw, pc, ig, hd, st);
      @(negedge clk_i);
      idle_on <= (ph != 6 && ph != 7);
      repeat (93) tick_q.push_back(next_tick());
      if (ph == 6) begin
        // receiver holds off while the sender keeps offering
        repeat (30) @(negedge clk_i);
        long_hold_go <= 1'b1;
        @(negedge clk_i);
        long_hold_go <= 1'b0;
      end
      drain();
    end

    err_cnt += fan_due.size();
    $display("Run covered %0d ticks under 12 register settings, %0d results checked,",
             n_ticks, n_results);
    $display("  %0d duty writes and %0d fault readings; %0d errors.", n_writes, n_faults,
             err_cnt);
    if (err_cnt == 0) begin
      $display("PASS fan_curve_speed_controller");
    end else begin
      $display("FAIL fan_curve_speed_controller");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL fan_curve_speed_controller");
    $finish;
  end

endmodule
